### rtl/core/srb_pkg.sv
// Shared types and constants for the sample ring buffer core.
// This package has no dependencies.
`timescale 1ns / 1ps

package srb_pkg;

  localparam int ACTION_W = 3;
  localparam int SAMPLE_W = 8;
  localparam int COUNT_W  = 13;
  localparam int LEVEL_W  = 13;
  localparam int STATUS_W = 3;
  localparam int TOTAL_W  = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_START   = 3'd0,
    ACT_STOP    = 3'd1,
    ACT_RESERVE = 3'd2,
    ACT_DATA    = 3'd3,
    ACT_READ    = 3'd4,
    ACT_SKIP    = 3'd5
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_IDLE     = 3'd1,
    ST_UNDERRUN = 3'd2,
    ST_REJECTED = 3'd3,
    ST_OVERRUN  = 3'd4
  } status_e;

endpackage

### rtl/core/sample_ring_buffer_with_prebuffer_core.sv
// Sample ring buffer core: control registers, sample memory and result pipeline.
// Depends on srb_pkg for field widths, action codes and status codes.
// A result is registered in the s1 stage and then in the output register after its request is accepted.
// Throughput: one request per cycle while the output is not stalled, set by the single sample memory port
// that serves either one write or one read for each request.
// Reset clears pointers, fill, counters and run state; the sample memory is not cleared.
`timescale 1ns / 1ps

module sample_ring_buffer_with_prebuffer_core #(
  parameter int CAPACITY = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [srb_pkg::LEVEL_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [srb_pkg::ACTION_W-1:0]  action_i,
  input  logic [srb_pkg::SAMPLE_W-1:0]  sample_in_i,
  input  logic [srb_pkg::COUNT_W-1:0]   count_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [srb_pkg::STATUS_W-1:0]  status_o,
  output logic [srb_pkg::SAMPLE_W-1:0]  sample_out_o,
  output logic                          ready_res_o,
  output logic [srb_pkg::LEVEL_W-1:0]   fill_level_o,
  output logic [srb_pkg::TOTAL_W-1:0]   underrun_total_o,
  output logic [srb_pkg::TOTAL_W-1:0]   overrun_total_o
);
  import srb_pkg::*;

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = ((CW > COUNT_W) ? CW : COUNT_W) + 1;
  localparam int SUMW = AW + 1;

  localparam logic [CMPW-1:0] CAP_CMP  = CMPW'(CAPACITY);
  localparam logic [AW-1:0]   PTR_LAST = AW'(CAPACITY - 1);
  localparam logic [SUMW-1:0] CAP_SUM  = SUMW'(CAPACITY);

  logic [SAMPLE_W-1:0] mem_q [CAPACITY];
  logic [SAMPLE_W-1:0] rdata_q;

  logic [LEVEL_W-1:0] prebuf_q;
  logic [CW-1:0]      latched_q, latched_d;
  logic [AW-1:0]      rptr_q, rptr_d, wptr_q, wptr_d;
  logic [CW-1:0]      fill_q, fill_d, resv_q, resv_d;
  logic               run_q, run_d;
  logic [TOTAL_W-1:0] under_q, under_d, over_q, over_d;

  logic               s1_valid_q, s1_read_q, s1_ready_q;
  logic [STATUS_W-1:0] s1_status_q;
  logic [CW-1:0]      s1_fill_q;
  logic [TOTAL_W-1:0] s1_under_q, s1_over_q;

  logic               out_valid_q, out_ready_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [SAMPLE_W-1:0] out_sample_q;
  logic [LEVEL_W-1:0] out_fill_q;
  logic [TOTAL_W-1:0] out_under_q, out_over_q;

  logic               s1_move, accept;
  logic               mem_we, mem_re, ok_read;
  status_e            status_d;
  logic [CMPW-1:0]    cnt_cmp, lvl_cmp, free_cmp, fill_cmp;
  logic [SUMW-1:0]    skip_sum;

  assign cfg_ready_o = 1'b1;
  assign s1_move     = !out_valid_q || !out_stall_i;
  assign in_stall_o  = s1_valid_q && !s1_move;
  assign accept      = in_valid_i && !in_stall_o;

  assign cnt_cmp  = CMPW'(count_i);
  assign lvl_cmp  = CMPW'(prebuf_q);
  assign fill_cmp = CMPW'(fill_q);
  assign free_cmp = CAP_CMP - fill_cmp;
  assign skip_sum = SUMW'(rptr_q) + SUMW'(count_i);

  always_comb begin
    rptr_d    = rptr_q;
    wptr_d    = wptr_q;
    fill_d    = fill_q;
    resv_d    = resv_q;
    run_d     = run_q;
    under_d   = under_q;
    over_d    = over_q;
    latched_d = latched_q;
    status_d  = ST_OK;
    mem_we    = 1'b0;
    ok_read   = 1'b0;
    case (action_i)
      ACT_START: begin
        if (prebuf_q == '0 || lvl_cmp > CAP_CMP) begin
          status_d = ST_REJECTED;
        end else begin
          rptr_d    = '0;
          wptr_d    = '0;
          fill_d    = '0;
          resv_d    = '0;
          under_d   = '0;
          over_d    = '0;
          latched_d = CW'(prebuf_q);
          run_d     = 1'b1;
        end
      end
      ACT_STOP: begin
        rptr_d = '0;
        wptr_d = '0;
        fill_d = '0;
        resv_d = '0;
        run_d  = 1'b0;
      end
      ACT_RESERVE: begin
        if (count_i == '0 || cnt_cmp > CAP_CMP) begin
          status_d = ST_REJECTED;
        end else if (!run_q) begin
          status_d = ST_IDLE;
        end else if (cnt_cmp > free_cmp) begin
          over_d   = over_q + 1'b1;
          status_d = ST_OVERRUN;
        end else begin
          resv_d = CW'(count_i);
        end
      end
      ACT_DATA: begin
        if (!run_q) begin
          status_d = ST_IDLE;
        end else if (resv_q == '0 || fill_cmp >= CAP_CMP) begin
          status_d = ST_REJECTED;
        end else begin
          mem_we = 1'b1;
          wptr_d = (wptr_q == PTR_LAST) ? '0 : wptr_q + 1'b1;
          fill_d = fill_q + 1'b1;
          resv_d = resv_q - 1'b1;
        end
      end
      ACT_READ: begin
        if (!run_q) begin
          status_d = ST_IDLE;
        end else if (fill_q == '0) begin
          under_d  = under_q + 1'b1;
          status_d = ST_UNDERRUN;
        end else begin
          ok_read = 1'b1;
          rptr_d  = (rptr_q == PTR_LAST) ? '0 : rptr_q + 1'b1;
          fill_d  = fill_q - 1'b1;
        end
      end
      ACT_SKIP: begin
        if (count_i == '0) begin
          status_d = ST_OK;
        end else if (!run_q) begin
          status_d = ST_IDLE;
        end else if (cnt_cmp > fill_cmp) begin
          rptr_d   = wptr_q;
          fill_d   = '0;
          under_d  = under_q + 1'b1;
          status_d = ST_UNDERRUN;
        end else begin
          rptr_d = (skip_sum >= CAP_SUM) ? AW'(skip_sum - CAP_SUM) : AW'(skip_sum);
          fill_d = fill_q - CW'(count_i);
        end
      end
      default: begin
        status_d = ST_REJECTED;
      end
    endcase
  end

  assign mem_re = accept && ok_read;

  always_ff @(posedge clk_i) begin
    if (accept && mem_we) begin
      mem_q[wptr_q] <= sample_in_i;
    end
    if (mem_re) begin
      rdata_q <= mem_q[rptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prebuf_q  <= LEVEL_W'(1);
      latched_q <= CW'(1);
      rptr_q    <= '0;
      wptr_q    <= '0;
      fill_q    <= '0;
      resv_q    <= '0;
      run_q     <= 1'b0;
      under_q   <= '0;
      over_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        prebuf_q <= cfg_data_i;
      end
      if (accept) begin
        latched_q <= latched_d;
        rptr_q    <= rptr_d;
        wptr_q    <= wptr_d;
        fill_q    <= fill_d;
        resv_q    <= resv_d;
        run_q     <= run_d;
        under_q   <= under_d;
        over_q    <= over_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_move) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_move) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_read_q   <= ok_read;
      s1_status_q <= status_d;
      s1_fill_q   <= fill_d;
      s1_ready_q  <= run_d && (fill_d >= latched_d);
      s1_under_q  <= under_d;
      s1_over_q   <= over_d;
    end
    if (s1_move && s1_valid_q) begin
      out_status_q <= s1_status_q;
      out_sample_q <= s1_read_q ? rdata_q : '0;
      out_ready_q  <= s1_ready_q;
      out_fill_q   <= LEVEL_W'(s1_fill_q);
      out_under_q  <= s1_under_q;
      out_over_q   <= s1_over_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign sample_out_o     = out_sample_q;
  assign ready_res_o      = out_ready_q;
  assign fill_level_o     = out_fill_q;
  assign underrun_total_o = out_under_q;
  assign overrun_total_o  = out_over_q;

endmodule
